### sv/hpd_pkg.sv
`timescale 1ns / 1ps

package hpd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 16;
  localparam int BYTE_BITS     = 8;
  localparam int COUNT_W       = 24;
  localparam int IDX_IN_W      = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  // The bit window holds an unmatched code prefix plus one fresh byte.
  localparam int WIN_W         = MAX_CODE_LEN + BYTE_BITS - 1;
  localparam int WLEN_W        = $clog2(WIN_W + 1);
  localparam int CMP_W         = (WIN_W > 16) ? WIN_W : 16;
  localparam int CNT_W         = $clog2(MAX_CODE_LEN + 1);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_EMIT,
    S_SHIFT
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  data_byte;
    logic [7:0]  entry_index;
    logic [15:0] entry_code;
    logic [4:0]  entry_length;
    logic [7:0]  entry_symbol;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
    logic       code_error;
  } out_t;

  typedef struct packed {
    logic [15:0] code;
    logic [4:0]  length;
    logic [7:0]  symbol;
  } entry_t;

endpackage

### sv/huffman_prefix_decoder.sv
// Flow: a data byte is taken into the bit window, then each code costs one pass over the code
// table to find the result, followed by a shift of the bit window down by the consumed code bits.
// Output stalls can hold the result; the input stays stalled until the byte is used up, so a
// new byte is not taken before the block is through with the last one.
// Reset (rst_ni low, asynchronous) clears all table slots to invalid at once, the bit
// window, the symbol counter and symbol_count; no clearing pass is needed.
`timescale 1ns / 1ps

module huffman_prefix_decoder import hpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  // Control state.
  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   emitted_q, emitted_d, emitted_inc;

  // Bit window: stream bits are left aligned, the oldest unconsumed bit sits at the
  // top. Bits below the valid length are always zero, so a new byte is ORed in.
  logic [WIN_W-1:0]     win_q, win_d, byte_ext;
  logic [WLEN_W-1:0]    wlen_q, wlen_d;
  logic [CNT_W-1:0]     shift_cnt_q, shift_cnt_d;
  // Number of leading window bits that were already tried against the table without a
  // match. A prefix held over from an earlier byte only grows; shorter codes are not
  // tried again, even when the table has been loaded since.
  logic [WLEN_W-1:0]    chk_q, chk_d;

  // Code table. Written marks live in flip-flops so that reset invalidates every
  // slot at once; the slot contents sit in a memory that is read once per cycle.
  entry_t               mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] written_q;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  // Table scan. One slot is read per cycle; its registered data is compared in the
  // following cycle against the bit window.
  logic [IDX_W-1:0]     scan_idx_q;
  logic                 scan_start, rd_issue;
  logic                 rd_pend_q, rd_ok_q;
  entry_t               rd_q;
  logic                 found_q;
  logic [4:0]           best_len_q;
  logic [7:0]           best_sym_q;
  logic [WLEN_W-1:0]    shamt;
  logic [CMP_W-1:0]     prefix, mask;
  logic                 hit, better;

  // Output register.
  logic                 out_valid_q;
  out_t                 out_data_q, out_next;
  logic                 out_free, out_load;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign emitted_inc = emitted_q + COUNT_W'(1);
  assign byte_ext    = WIN_W'(in_data_i.data_byte) << (WIN_W - BYTE_BITS);

  assign mem_waddr = in_data_i.entry_index[IDX_W-1:0];
  assign mem_wdata = '{code:   in_data_i.entry_code,
                       length: in_data_i.entry_length,
                       symbol: in_data_i.entry_symbol};

  // A slot matches when its length fits both the code limit and the bits held in
  // the window, is longer than the prefix already tried, and its right-aligned code
  // equals the window's leading bits. Slots arrive in ascending order, so a strictly
  // shorter match replaces the best one and ties keep the lower index.
  always_comb begin
    shamt  = WLEN_W'(WIN_W) - WLEN_W'(rd_q.length);
    prefix = CMP_W'(win_q >> shamt);
    mask   = ~({CMP_W{1'b1}} << rd_q.length);
    hit    = rd_pend_q && rd_ok_q && (rd_q.length != 5'd0) &&
             (int'(rd_q.length) <= MAX_CODE_LEN) &&
             (int'(rd_q.length) <= int'(wlen_q)) &&
             (int'(rd_q.length) > int'(chk_q)) &&
             (((prefix ^ CMP_W'(rd_q.code)) & mask) == '0);
    better = hit && (!found_q || (rd_q.length < best_len_q));
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    wlen_d      = wlen_q;
    chk_d       = chk_q;
    emitted_d   = emitted_q;
    shift_cnt_d = shift_cnt_q;
    scan_start  = 1'b0;
    rd_issue    = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    out_next    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.command)
            CMD_LOAD: begin
              mem_we = ((IDX_IN_W + 1)'(in_data_i.entry_index) <
                        (IDX_IN_W + 1)'(TABLE_ENTRIES));
            end
            CMD_RESTART: begin
              win_d     = '0;
              wlen_d    = '0;
              chk_d     = '0;
              emitted_d = '0;
            end
            CMD_DATA: begin
              if (emitted_q >= count_q) begin
                // Stream complete: the byte is dropped with any held prefix.
                win_d  = '0;
                wlen_d = '0;
                chk_d  = '0;
              end else begin
                win_d      = win_q | (byte_ext >> wlen_q);
                wlen_d     = wlen_q + WLEN_W'(BYTE_BITS);
                chk_d      = wlen_q;
                scan_start = 1'b1;
                state_d    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        rd_issue = 1'b1;
        if (scan_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!found_q && (wlen_q < WLEN_W'(MAX_CODE_LEN))) begin
          // No code yet within the bits at hand: keep the prefix for the next byte.
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          if (found_q) begin
            out_next    = '{symbol: best_sym_q,
                            last_symbol: (emitted_inc == count_q),
                            code_error: 1'b0};
            emitted_d   = emitted_inc;
            shift_cnt_d = CNT_W'(best_len_q);
            if (emitted_inc >= count_q) begin
              // Last symbol: the padding bits behind it are discarded.
              win_d   = '0;
              wlen_d  = '0;
              chk_d   = '0;
              state_d = S_IDLE;
            end else begin
              state_d = S_SHIFT;
            end
          end else begin
            out_next    = '{symbol: 8'd0, last_symbol: 1'b0, code_error: 1'b1};
            shift_cnt_d = CNT_W'(MAX_CODE_LEN);
            state_d     = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        win_d       = win_q << 1;
        wlen_d      = wlen_q - WLEN_W'(1);
        shift_cnt_d = shift_cnt_q - CNT_W'(1);
        if (shift_cnt_q == CNT_W'(1)) begin
          // The bits behind a consumed code have not been tried yet.
          chk_d = '0;
          if (wlen_q != WLEN_W'(1)) begin
            scan_start = 1'b1;
            state_d    = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
    end else begin
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      emitted_q   <= '0;
      win_q       <= '0;
      wlen_q      <= '0;
      chk_q       <= '0;
      shift_cnt_q <= '0;
      written_q   <= '0;
      scan_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      emitted_q   <= emitted_d;
      win_q       <= win_d;
      wlen_q      <= wlen_d;
      chk_q       <= chk_d;
      shift_cnt_q <= shift_cnt_d;
      if (mem_we) begin
        written_q[mem_waddr] <= 1'b1;
      end
      if (scan_start) begin
        scan_idx_q <= '0;
      end else if (rd_issue) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      rd_pend_q <= rd_issue;
      rd_ok_q   <= written_q[scan_idx_q];
      if (scan_start) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_len_q <= rd_q.length;
      best_sym_q <= rd_q.symbol;
    end
    if (out_load) begin
      out_data_q <= out_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_issue) begin
      rd_q <= mem[scan_idx_q];
    end
  end

endmodule

### sv/hpd_chk.sv
`timescale 1ns / 1ps

module hpd_chk import hpd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Table loads and restarts leave the block ready to take the next input.
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CMD_LOAD) |=> !in_stall_o)
    else $error("block busy after a table load");

  a_restart_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CMD_RESTART) |=> !in_stall_o)
    else $error("block busy after a restart");

  // An error result carries symbol zero and never closes the stream.
  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.code_error |->
      (out_data_o.symbol == 8'd0) && !out_data_o.last_symbol)
    else $error("malformed error result");

endmodule

bind huffman_prefix_decoder hpd_chk u_hpd_chk (.*);
